// ===== rtl/gps_position_kalman_smoother_defines.svh =====
// Assertion macros for the position smoother checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef GPS_POSITION_KALMAN_SMOOTHER_DEFINES_SVH
`define GPS_POSITION_KALMAN_SMOOTHER_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define GPKS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gpks check failed");

// The consequent must hold in the same cycle as the antecedent.
`define GPKS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gpks check failed");

`endif

// ===== rtl/gpks_pkg.sv =====
// Shared types and constants of the position smoother.
// Used by the controller, the datapath, the divider and the top level.
package gpks_pkg;

	localparam int unsigned CFG_W = 16;

	// Configuration register indexes
	localparam logic REG_MIN_ACC = 1'b0;
	localparam logic REG_SPEED   = 1'b1;

	// Configuration reset values
	localparam logic [CFG_W-1:0] MIN_ACC_RST = 16'd16;
	localparam logic [CFG_W-1:0] SPEED_RST   = 16'd768;

	// Arithmetic constants
	localparam logic [31:0] VAR_MAX    = 32'hFFFF_FFFF;
	localparam logic [63:0] GROW_SAT   = 64'd256000 << 32;
	localparam logic [16:0] GAIN_ONE   = 17'h1_0000;
	localparam logic [63:0] ROUND_HALF = 64'd32768;

	// ceil(2^34 / 125): exact quotient by 125 for operands below 2^27
	localparam logic [27:0] GROW_RECIP = 28'd137438954;

	// Divider step count for the gain
	localparam logic [5:0] K_DIV_STEPS = 6'd17;

	// Datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ACC2_MUL,
		OP_ACC2_SAVE,
		OP_INIT,
		OP_Q2_MUL,
		OP_GROW_MUL,
		OP_GROW_HI,
		OP_GROW_REM,
		OP_GROW_LO,
		OP_GROW_ADD,
		OP_DEN,
		OP_K_DIV_START,
		OP_K_SAVE,
		OP_LAT_DIFF,
		OP_LAT_MUL,
		OP_LAT_UPD,
		OP_LNG_DIFF,
		OP_LNG_MUL,
		OP_LNG_UPD,
		OP_VAR_MUL,
		OP_VAR_UPD,
		OP_PUBLISH
	} dp_op_t;

	// Datapath status seen by the controller
	typedef struct packed {
		logic initialised;
		logic dt_pos;
		logic div_done;
	} dp_status_t;

endpackage

// ===== rtl/gpks_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Uses gpks_pkg; serves the gain step of the datapath.
module gpks_div
	import gpks_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] rem_init,
	input  logic [31:0] low_init,
	input  logic [32:0] divisor,
	input  logic [5:0]  steps,
	output logic        done,
	output logic [31:0] quotient
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [32:0] rem_q;
	logic [31:0] low_q;
	logic [32:0] dvs_q;
	logic [31:0] quot_q;
	logic [33:0] trial;
	logic        fits;

	// Shift in the next dividend bit and compare
	assign trial = {rem_q, low_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Flag the last step
	assign done     = busy_q && (cnt_q == 6'd1);
	assign quotient = quot_q;

	// Control: load on start, count steps down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 6'd1;
			busy_q <= (cnt_q != 6'd1);
		end
	end

	// Data: remainder, dividend bits and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			low_q  <= low_init;
			dvs_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? 33'(trial - {1'b0, dvs_q}) : trial[32:0];
			low_q  <= {low_q[30:0], 1'b0};
			quot_q <= {quot_q[30:0], fits};
		end
	end

endmodule

// ===== rtl/gpks_dp.sv =====
// Datapath of the position smoother: filter state, shared multiplier, divider.
// Uses gpks_pkg and gpks_div; driven one operation per cycle by gpks_ctrl.
module gpks_dp
	import gpks_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dp_op_t             op,
	output dp_status_t         status,
	input  logic signed [30:0] lat_meas,
	input  logic signed [31:0] lng_meas,
	input  logic [15:0]        accuracy,
	input  logic [31:0]        timestamp_ms,
	input  logic [CFG_W-1:0]   min_accuracy,
	input  logic [CFG_W-1:0]   process_noise_speed,
	output logic signed [30:0] lat_est,
	output logic signed [31:0] lng_est,
	output logic [31:0]        variance_out
);

	// Item registers
	logic signed [30:0] lat_in_q;
	logic signed [31:0] lng_in_q;
	logic [15:0]        acc_q;
	logic [31:0]        ts_q;

	// Working registers
	logic [31:0]        acc2_q;
	logic signed [63:0] prod_q;
	logic               sat_q;
	logic [18:0]        grow_xh_q;
	logic [19:0]        grow_lo_q;
	logic [11:0]        grow_qh_q;
	logic [26:0]        grow_y_q;
	logic [32:0]        den_q;
	logic [16:0]        k_q;
	logic signed [32:0] diff_q;

	// Filter state
	logic               init_q;
	logic signed [31:0] lat_state_q;
	logic signed [31:0] lng_state_q;
	logic [31:0]        var_q;
	logic [31:0]        last_time_q;

	// Result registers
	logic signed [30:0] lat_out_q;
	logic signed [31:0] lng_out_q;
	logic [31:0]        var_out_q;

	logic [31:0]        dt;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] mul_p;
	logic               div_start;
	logic [32:0]        div_rem;
	logic [31:0]        div_low;
	logic [32:0]        div_dvs;
	logic               div_done;
	logic [31:0]        div_quot;
	logic [18:0]        grow_rem;
	logic [31:0]        grow_quot;
	logic [32:0]        grow_sum;
	logic [48:0]        k_num;
	logic [16:0]        k_raw;
	logic signed [63:0] lat_sum;
	logic signed [63:0] lng_sum;
	logic [63:0]        var_sum;

	// Elapsed time, read as signed
	assign dt = ts_q - last_time_q;

	assign status.initialised = init_q;
	assign status.dt_pos      = !dt[31] && (dt != 32'd0);
	assign status.div_done    = div_done;

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (op)
			OP_ACC2_MUL: begin
				mul_a = $signed({17'b0, acc_q});
				mul_b = $signed({17'b0, acc_q});
			end
			OP_Q2_MUL: begin
				mul_a = $signed({17'b0, process_noise_speed});
				mul_b = $signed({17'b0, process_noise_speed});
			end
			OP_GROW_MUL: begin
				mul_a = $signed({2'b0, dt[30:0]});
				mul_b = $signed({1'b0, prod_q[31:0]});
			end
			// Upper digit of the growth product over 2^11, times 1/125
			OP_GROW_HI: begin
				mul_a = $signed({14'b0, prod_q[49:31]});
				mul_b = $signed({5'b0, GROW_RECIP});
			end
			// Remainder and lower digit, times 1/125
			OP_GROW_LO: begin
				mul_a = $signed({6'b0, grow_y_q});
				mul_b = $signed({5'b0, GROW_RECIP});
			end
			OP_LAT_MUL, OP_LNG_MUL: begin
				mul_a = diff_q;
				mul_b = $signed({16'b0, k_q});
			end
			OP_VAR_MUL: begin
				mul_a = $signed({16'b0, 17'(GAIN_ONE - k_q)});
				mul_b = $signed({1'b0, var_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Divider operands for the gain
	assign k_num     = {1'b0, var_q, 16'b0} + {17'b0, den_q[32:1]};
	assign div_start = (op == OP_K_DIV_START);
	assign div_rem   = {1'b0, k_num[48:17]};
	assign div_low   = {k_num[16:0], 15'b0};
	assign div_dvs   = den_q;

	gpks_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.low_init (div_low),
		.divisor  (div_dvs),
		.steps    (K_DIV_STEPS),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Growth over 256000: drop 11 bits, then divide by 125 in two digits
	assign grow_rem  = grow_xh_q - ({7'b0, prod_q[45:34]} * 19'd125);
	assign grow_quot = {grow_qh_q, prod_q[53:34]};

	// Update sums
	assign grow_sum = {1'b0, var_q} + {1'b0, grow_quot};
	assign k_raw    = (div_quot[16:0] > GAIN_ONE) ? GAIN_ONE : div_quot[16:0];
	assign lat_sum  = {{16{lat_state_q[31]}}, lat_state_q, 16'b0} + prod_q
		+ $signed(ROUND_HALF);
	assign lng_sum  = {{16{lng_state_q[31]}}, lng_state_q, 16'b0} + prod_q
		+ $signed(ROUND_HALF);
	assign var_sum  = $unsigned(prod_q) + ROUND_HALF;

	// Filter state and its control flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q      <= 1'b0;
			lat_state_q <= '0;
			lng_state_q <= '0;
			var_q       <= '0;
			last_time_q <= '0;
		end else begin
			case (op)
				OP_INIT: begin
					init_q      <= 1'b1;
					lat_state_q <= 32'(lat_in_q);
					lng_state_q <= lng_in_q;
					var_q       <= acc2_q;
					last_time_q <= ts_q;
				end
				OP_GROW_ADD: begin
					var_q       <= (sat_q || grow_sum[32]) ? VAR_MAX : grow_sum[31:0];
					last_time_q <= ts_q;
				end
				OP_LAT_UPD: lat_state_q <= lat_sum[47:16];
				OP_LNG_UPD: lng_state_q <= lng_sum[47:16];
				OP_VAR_UPD: var_q       <= var_sum[47:16];
				default: begin
					init_q <= init_q;
				end
			endcase
		end
	end

	// Item and working registers
	always_ff @(posedge clk) begin
		if (op inside {OP_ACC2_MUL, OP_Q2_MUL, OP_GROW_MUL, OP_GROW_HI, OP_GROW_LO,
			OP_LAT_MUL, OP_LNG_MUL, OP_VAR_MUL}) begin
			prod_q <= mul_p[63:0];
		end
		case (op)
			OP_LOAD: begin
				lat_in_q <= lat_meas;
				lng_in_q <= lng_meas;
				acc_q    <= (accuracy < min_accuracy) ? min_accuracy : accuracy;
				ts_q     <= timestamp_ms;
			end
			OP_ACC2_SAVE: acc2_q <= prod_q[31:0];
			OP_GROW_HI: begin
				sat_q     <= $unsigned(prod_q) >= GROW_SAT;
				grow_xh_q <= prod_q[49:31];
				grow_lo_q <= prod_q[30:11];
			end
			OP_GROW_REM: begin
				grow_qh_q <= prod_q[45:34];
				grow_y_q  <= {grow_rem[6:0], grow_lo_q};
			end
			OP_DEN:    den_q <= {1'b0, var_q} + {1'b0, acc2_q};
			OP_K_SAVE: k_q   <= (den_q == 33'd0) ? 17'd0 : k_raw;
			OP_LAT_DIFF: begin
				diff_q <= 33'(lat_in_q) - 33'(lat_state_q);
			end
			OP_LNG_DIFF: begin
				diff_q <= 33'(lng_in_q) - 33'(lng_state_q);
			end
			OP_PUBLISH: begin
				lat_out_q <= lat_state_q[30:0];
				lng_out_q <= lng_state_q;
				var_out_q <= var_q;
			end
			default: begin
				ts_q <= ts_q;
			end
		endcase
	end

	assign lat_est      = lat_out_q;
	assign lng_est      = lng_out_q;
	assign variance_out = var_out_q;

endmodule

// ===== rtl/gpks_ctrl.sv =====
// Controller of the position smoother: sequences datapath operations per item.
// Uses gpks_pkg; drives gpks_dp through its operation code and status.
module gpks_ctrl
	import gpks_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	input  dp_status_t status,
	output dp_op_t     op
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_ACC2,
		S_ACC2_SAVE,
		S_INIT,
		S_Q2,
		S_GROW_MUL,
		S_GROW_HI,
		S_GROW_REM,
		S_GROW_LO,
		S_GROW_ADD,
		S_DEN,
		S_K_DIV_START,
		S_K_DIV,
		S_K_SAVE,
		S_LAT_DIFF,
		S_LAT_MUL,
		S_LAT_UPD,
		S_LNG_DIFF,
		S_LNG_MUL,
		S_LNG_UPD,
		S_VAR_MUL,
		S_VAR_UPD,
		S_PUBLISH
	} state_t;

	state_t state_q;
	logic   m_tvalid_q;
	logic   pub_ok;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign pub_ok   = !m_tvalid_q || m_tready;

	// Operation for the current state
	always_comb begin
		unique case (state_q)
			S_IDLE:        op = s_tvalid ? OP_LOAD : OP_NONE;
			S_ACC2:        op = OP_ACC2_MUL;
			S_ACC2_SAVE:   op = OP_ACC2_SAVE;
			S_INIT:        op = OP_INIT;
			S_Q2:          op = OP_Q2_MUL;
			S_GROW_MUL:    op = OP_GROW_MUL;
			S_GROW_HI:     op = OP_GROW_HI;
			S_GROW_REM:    op = OP_GROW_REM;
			S_GROW_LO:     op = OP_GROW_LO;
			S_GROW_ADD:    op = OP_GROW_ADD;
			S_DEN:         op = OP_DEN;
			S_K_DIV_START: op = OP_K_DIV_START;
			S_K_DIV:       op = OP_NONE;
			S_K_SAVE:      op = OP_K_SAVE;
			S_LAT_DIFF:    op = OP_LAT_DIFF;
			S_LAT_MUL:     op = OP_LAT_MUL;
			S_LAT_UPD:     op = OP_LAT_UPD;
			S_LNG_DIFF:    op = OP_LNG_DIFF;
			S_LNG_MUL:     op = OP_LNG_MUL;
			S_LNG_UPD:     op = OP_LNG_UPD;
			S_VAR_MUL:     op = OP_VAR_MUL;
			S_VAR_UPD:     op = OP_VAR_UPD;
			S_PUBLISH:     op = pub_ok ? OP_PUBLISH : OP_NONE;
			default:       op = OP_NONE;
		endcase
	end

	// Advance the sequence and hold the result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == S_PUBLISH && pub_ok) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:      if (s_tvalid) state_q <= S_ACC2;
				S_ACC2:      state_q <= S_ACC2_SAVE;
				S_ACC2_SAVE: begin
					if (!status.initialised) begin
						state_q <= S_INIT;
					end else if (status.dt_pos) begin
						state_q <= S_Q2;
					end else begin
						state_q <= S_DEN;
					end
				end
				S_INIT:        state_q <= S_PUBLISH;
				S_Q2:          state_q <= S_GROW_MUL;
				S_GROW_MUL:    state_q <= S_GROW_HI;
				S_GROW_HI:     state_q <= S_GROW_REM;
				S_GROW_REM:    state_q <= S_GROW_LO;
				S_GROW_LO:     state_q <= S_GROW_ADD;
				S_GROW_ADD:    state_q <= S_DEN;
				S_DEN:         state_q <= S_K_DIV_START;
				S_K_DIV_START: state_q <= S_K_DIV;
				S_K_DIV:       if (status.div_done) state_q <= S_K_SAVE;
				S_K_SAVE:      state_q <= S_LAT_DIFF;
				S_LAT_DIFF:    state_q <= S_LAT_MUL;
				S_LAT_MUL:     state_q <= S_LAT_UPD;
				S_LAT_UPD:     state_q <= S_LNG_DIFF;
				S_LNG_DIFF:    state_q <= S_LNG_MUL;
				S_LNG_MUL:     state_q <= S_LNG_UPD;
				S_LNG_UPD:     state_q <= S_VAR_MUL;
				S_VAR_MUL:     state_q <= S_VAR_UPD;
				S_VAR_UPD:     state_q <= S_PUBLISH;
				S_PUBLISH:     if (pub_ok) state_q <= S_IDLE;
				default:       state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/gps_position_kalman_smoother.sv =====
// Top level of the scalar position smoother for GPS fixes.
// Uses gpks_pkg, gpks_ctrl and gpks_dp; holds the configuration registers.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+----------------------------------
//   s_*      | in        | s_tvalid/tready  | one position fix
//   m_*      | out       | m_tvalid/tready  | filtered position and variance
//   cfg_*    | in        | cfg_we           | min_accuracy, process_noise_speed
//
// One fix at a time. The gain comes from the 17-step bit-serial divider; the
// variance growth is skipped when time does not advance, and the first fix only
// initialises the filter state and publishes it.
// The result waits in an output register, so the next fix is taken while it stalls;
// that fix then holds at its publish step until the waiting result is taken.
// Reset clears the filter state and loads the configuration defaults.
module gps_position_kalman_smoother
	import gpks_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// lat_meas[30:0], lng_meas[62:31], accuracy[78:63], timestamp_ms[110:79], pad
	input  logic [111:0]     s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// lat_est[30:0], lng_est[62:31], variance_out[94:63], pad
	output logic [95:0]      m_tdata,
	input  logic             cfg_we,
	input  logic             cfg_addr,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic [CFG_W-1:0]   min_acc_q;
	logic [CFG_W-1:0]   speed_q;
	dp_op_t             op;
	dp_status_t         status;
	logic signed [30:0] lat_est;
	logic signed [31:0] lng_est;
	logic [31:0]        variance_out;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_acc_q <= MIN_ACC_RST;
			speed_q   <= SPEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MIN_ACC: min_acc_q <= cfg_wdata;
				REG_SPEED:   speed_q   <= cfg_wdata;
				default:     min_acc_q <= min_acc_q;
			endcase
		end
	end

	gpks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.op       (op)
	);

	gpks_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.op                  (op),
		.status              (status),
		.lat_meas            ($signed(s_tdata[30:0])),
		.lng_meas            ($signed(s_tdata[62:31])),
		.accuracy            (s_tdata[78:63]),
		.timestamp_ms        (s_tdata[110:79]),
		.min_accuracy        (min_acc_q),
		.process_noise_speed (speed_q),
		.lat_est             (lat_est),
		.lng_est             (lng_est),
		.variance_out        (variance_out)
	);

	// Pack the result
	assign m_tdata = {1'b0, variance_out, lng_est, lat_est};

endmodule

// ===== rtl/gpks_checker.sv =====
// Port-level checks for the position smoother, bound to the top level.
// Uses the macros of gps_position_kalman_smoother_defines.svh.
`include "gps_position_kalman_smoother_defines.svh"

module gpks_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [95:0] m_tdata
);

	// A stalled result holds
	`GPKS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// One item at a time: the input closes after an accept
	`GPKS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

	// A result never appears the cycle after an accept
	`GPKS_ASSERT_NEXT(a_no_instant, s_tvalid && s_tready, !$rose(m_tvalid))

	// A new result never rises just after an item is taken
	`GPKS_ASSERT_NOW(a_rise_idle, $rose(m_tvalid), !$past(s_tvalid && s_tready))

endmodule

bind gps_position_kalman_smoother gpks_checker u_gpks_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
